>>> sv/rtnh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnh_pkg
// Types and constants shared by the ray/triangle nearest-hit block.
// ----------------------------------------------------------------------------
package rtnh_pkg;

  localparam int VW = 104;  // signed width of dot products
  localparam int MW = VW - 1;  // magnitude width of queued dot products
  localparam int QB = 31;  // quotient bits per division
  localparam int RW = VW + 32;  // divider remainder width
  localparam int CH = 23;  // multiplier chunk width
  localparam int NSTEP = 24;  // products per triangle

  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] CFG_DIR_X = 3'd3;
  localparam logic [2:0] CFG_DIR_Y = 3'd4;
  localparam logic [2:0] CFG_DIR_Z = 3'd5;
  localparam logic [2:0] CFG_LIMIT = 3'd6;
  localparam logic [2:0] CFG_EPSILON = 3'd7;

  typedef struct packed {
    logic restart;
    logic signed [31:0] v0_x;
    logic signed [31:0] v0_y;
    logic signed [31:0] v0_z;
    logic signed [31:0] v1_x;
    logic signed [31:0] v1_y;
    logic signed [31:0] v1_z;
    logic signed [31:0] v2_x;
    logic signed [31:0] v2_y;
    logic signed [31:0] v2_z;
    logic [15:0] instance_id;
    logic [15:0] triangle_id;
  } in_t;

  typedef struct packed {
    logic updated;
    logic any_hit;
    logic [30:0] nearest_distance;
    logic [16:0] nearest_u;
    logic [16:0] nearest_v;
    logic [15:0] nearest_triangle;
    logic [15:0] nearest_instance;
  } out_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_cfg_t;

  typedef struct packed {
    logic restart;
    logic cand;
    logic [MW-1:0] det;
    logic [MW-1:0] nu;
    logic [MW-1:0] nv;
    logic [MW-1:0] nt;
    logic [15:0] instance_id;
    logic [15:0] triangle_id;
  } qitem_t;

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_ACC, F_FIX, F_PUSH} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_DIV_T, B_DIV_U, B_DIV_V, B_OUT} back_state_t;

endpackage

>>> sv/rtnh_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnh_fifo
// Two-entry queue between the classifying front and the dividing back.
// ----------------------------------------------------------------------------
module rtnh_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rtnh_pkg::qitem_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output rtnh_pkg::qitem_t rdata
);
  import rtnh_pkg::*;

  qitem_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/rtnh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnh_front
// Accept a triangle, form edges and the cross and dot products on one shared
// chunked multiplier, fix the determinant sign and classify the candidate.
// ----------------------------------------------------------------------------
module rtnh_front #(
  parameter int FRAC_BITS        = 16,
  parameter int INSTANCE_ID_BITS = 16,
  parameter int TRIANGLE_ID_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rtnh_pkg::in_t      in_data,
  input  rtnh_pkg::ray_cfg_t ray,
  input  logic [15:0]        epsilon,
  output logic               push,
  input  logic               full,
  output rtnh_pkg::qitem_t   item
);
  import rtnh_pkg::*;

  localparam logic [15:0] INST_MASK = 16'((32'd1 << INSTANCE_ID_BITS) - 1);
  localparam logic [15:0] TRI_MASK  = 16'((32'd1 << TRIANGLE_ID_BITS) - 1);

  front_state_t state, state_next;

  logic signed [32:0] e1 [3];
  logic signed [32:0] e2 [3];
  logic signed [32:0] tv [3];
  logic signed [32:0] dv [3];
  logic signed [67:0] pv [3];
  logic signed [67:0] qv [3];
  logic signed [VW-1:0] det_r, nu_r, nv_r, nt_r, acc;
  logic [100:0] prod;
  logic [4:0]   step;
  logic [1:0]   phase;
  logic         restart;
  logic [15:0]  inst_id, tri_id;

  logic signed [32:0] a_op;
  logic signed [67:0] b_op;
  logic               neg_op, first_op, last_op;
  logic [32:0]        a_mag;
  logic [67:0]        b_mag;
  logic [68:0]        b_pad;
  logic [CH-1:0]      chunk;
  logic [55:0]        part;
  logic [100:0]       part_sh;
  logic signed [VW-1:0] prod_s, acc_new;
  logic [VW-1:0]      eps_th;
  logic signed [VW:0] uv_sum;

  assign dv[0] = 33'(ray.dir_x);
  assign dv[1] = 33'(ray.dir_y);
  assign dv[2] = 33'(ray.dir_z);

  always_comb begin
    a_op = '0; b_op = '0; neg_op = 1'b0;
    unique case (step)
      5'd0:  begin a_op = dv[1]; b_op = 68'(e2[2]); end
      5'd1:  begin a_op = dv[2]; b_op = 68'(e2[1]); neg_op = 1'b1; end
      5'd2:  begin a_op = dv[2]; b_op = 68'(e2[0]); end
      5'd3:  begin a_op = dv[0]; b_op = 68'(e2[2]); neg_op = 1'b1; end
      5'd4:  begin a_op = dv[0]; b_op = 68'(e2[1]); end
      5'd5:  begin a_op = dv[1]; b_op = 68'(e2[0]); neg_op = 1'b1; end
      5'd6:  begin a_op = tv[1]; b_op = 68'(e1[2]); end
      5'd7:  begin a_op = tv[2]; b_op = 68'(e1[1]); neg_op = 1'b1; end
      5'd8:  begin a_op = tv[2]; b_op = 68'(e1[0]); end
      5'd9:  begin a_op = tv[0]; b_op = 68'(e1[2]); neg_op = 1'b1; end
      5'd10: begin a_op = tv[0]; b_op = 68'(e1[1]); end
      5'd11: begin a_op = tv[1]; b_op = 68'(e1[0]); neg_op = 1'b1; end
      5'd12: begin a_op = e1[0]; b_op = pv[0]; end
      5'd13: begin a_op = e1[1]; b_op = pv[1]; end
      5'd14: begin a_op = e1[2]; b_op = pv[2]; end
      5'd15: begin a_op = tv[0]; b_op = pv[0]; end
      5'd16: begin a_op = tv[1]; b_op = pv[1]; end
      5'd17: begin a_op = tv[2]; b_op = pv[2]; end
      5'd18: begin a_op = dv[0]; b_op = qv[0]; end
      5'd19: begin a_op = dv[1]; b_op = qv[1]; end
      5'd20: begin a_op = dv[2]; b_op = qv[2]; end
      5'd21: begin a_op = e2[0]; b_op = qv[0]; end
      5'd22: begin a_op = e2[1]; b_op = qv[1]; end
      5'd23: begin a_op = e2[2]; b_op = qv[2]; end
      default: begin a_op = '0; b_op = '0; end
    endcase
  end

  always_comb begin
    first_op = (step < 5'd12) ? ~step[0] :
               (step == 5'd12 || step == 5'd15 || step == 5'd18 || step == 5'd21);
    last_op  = (step < 5'd12) ? step[0] :
               (step == 5'd14 || step == 5'd17 || step == 5'd20 || step == 5'd23);
  end

  assign a_mag = a_op[32] ? 33'(-a_op) : 33'(a_op);
  assign b_mag = b_op[67] ? 68'(-b_op) : 68'(b_op);
  assign b_pad = {1'b0, b_mag};

  always_comb begin
    unique case (phase)
      2'd0:    chunk = b_pad[CH-1:0];
      2'd1:    chunk = b_pad[2*CH-1:CH];
      default: chunk = b_pad[3*CH-1:2*CH];
    endcase
  end

  assign part = 56'(a_mag) * 56'(chunk);

  always_comb begin
    unique case (phase)
      2'd0:    part_sh = 101'(part);
      2'd1:    part_sh = 101'(part) << CH;
      default: part_sh = 101'(part) << (2 * CH);
    endcase
  end

  assign prod_s  = (a_op[32] ^ b_op[67] ^ neg_op) ? -$signed(VW'(prod))
                                                  : $signed(VW'(prod));
  assign acc_new = (first_op ? '0 : acc) + prod_s;

  assign eps_th = VW'(epsilon) << (2 * FRAC_BITS);
  assign uv_sum = (VW+1)'(nu_r) + (VW+1)'(nv_r);

  always_comb begin
    item.restart     = restart;
    item.cand        = (det_r != '0) && ($unsigned(det_r) >= eps_th)
                       && !nu_r[VW-1] && (nu_r <= det_r)
                       && !nv_r[VW-1] && (uv_sum <= (VW+1)'(det_r))
                       && !nt_r[VW-1] && (nt_r != '0);
    item.det         = det_r[MW-1:0];
    item.nu          = nu_r[MW-1:0];
    item.nv          = nv_r[MW-1:0];
    item.nt          = nt_r[MW-1:0];
    item.instance_id = inst_id & INST_MASK;
    item.triangle_id = tri_id & TRI_MASK;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (in_valid) begin
        state_next = F_MUL;
      end
      F_MUL: if (phase == 2'd2) begin
        state_next = F_ACC;
      end
      F_ACC: begin
        state_next = (step == 5'(NSTEP - 1)) ? F_FIX : F_MUL;
      end
      F_FIX: state_next = F_PUSH;
      F_PUSH: if (!full) begin
        state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != F_IDLE);
    push     = (state == F_PUSH) && !full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        step  <= '0;
        phase <= '0;
        prod  <= '0;
        if (in_valid) begin
          restart <= in_data.restart;
          inst_id <= in_data.instance_id;
          tri_id  <= in_data.triangle_id;
          e1[0] <= 33'(in_data.v1_x) - 33'(in_data.v0_x);
          e1[1] <= 33'(in_data.v1_y) - 33'(in_data.v0_y);
          e1[2] <= 33'(in_data.v1_z) - 33'(in_data.v0_z);
          e2[0] <= 33'(in_data.v2_x) - 33'(in_data.v0_x);
          e2[1] <= 33'(in_data.v2_y) - 33'(in_data.v0_y);
          e2[2] <= 33'(in_data.v2_z) - 33'(in_data.v0_z);
          tv[0] <= 33'(ray.origin_x) - 33'(in_data.v0_x);
          tv[1] <= 33'(ray.origin_y) - 33'(in_data.v0_y);
          tv[2] <= 33'(ray.origin_z) - 33'(in_data.v0_z);
        end
      end
      F_MUL: begin
        prod  <= prod + part_sh;
        phase <= phase + 2'd1;
      end
      F_ACC: begin
        acc   <= acc_new;
        prod  <= '0;
        phase <= '0;
        step  <= step + 5'd1;
        if (last_op) begin
          unique case (step)
            5'd1:    pv[0] <= acc_new[67:0];
            5'd3:    pv[1] <= acc_new[67:0];
            5'd5:    pv[2] <= acc_new[67:0];
            5'd7:    qv[0] <= acc_new[67:0];
            5'd9:    qv[1] <= acc_new[67:0];
            5'd11:   qv[2] <= acc_new[67:0];
            5'd14:   det_r <= acc_new;
            5'd17:   nu_r  <= acc_new;
            5'd20:   nv_r  <= acc_new;
            default: nt_r  <= acc_new;
          endcase
        end
      end
      F_FIX: begin
        if (det_r[VW-1]) begin
          det_r <= -det_r;
          nu_r  <= -nu_r;
          nv_r  <= -nv_r;
          nt_r  <= -nt_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/rtnh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnh_div
// Restoring divider, one quotient bit per cycle, QB bits per division.
// ----------------------------------------------------------------------------
module rtnh_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [rtnh_pkg::RW-1:0] dividend,
  input  logic [rtnh_pkg::MW-1:0] divisor,
  output logic                    done,
  output logic [rtnh_pkg::QB-1:0] quotient
);
  import rtnh_pkg::*;

  localparam int CW = $clog2(QB);

  logic [RW-1:0] rem, dsh;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= RW'(divisor) << (QB - 1);
      cnt <= CW'(QB - 1);
    end else if (busy) begin
      rem      <= ge ? rem - dsh : rem;
      dsh      <= dsh >> 1;
      quotient <= {quotient[QB-2:0], ge};
      cnt      <= cnt - 1'b1;
    end
  end

endmodule

>>> sv/rtnh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnh_back
// Take classified triangles from the queue, divide out distance and
// barycentrics, keep the nearest hit and present one result per triangle.
// ----------------------------------------------------------------------------
module rtnh_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  output logic             pop,
  input  rtnh_pkg::qitem_t head,
  input  logic [30:0]      distance_limit,
  input  logic [15:0]      epsilon,
  output logic             out_valid,
  input  logic             out_stall,
  output rtnh_pkg::out_t   out_data
);
  import rtnh_pkg::*;

  back_state_t state, state_next;

  qitem_t        cur;
  logic          ovf;
  logic          upd;
  logic [30:0]   tq;
  logic [16:0]   u_tmp;
  logic [30:0]   best_dist;
  logic [16:0]   best_u, best_v;
  logic [15:0]   best_tri, best_inst;
  logic          hit_held;

  logic          div_start, div_done;
  logic [RW-1:0] div_dividend;
  logic [MW-1:0] div_divisor;
  logic [QB-1:0] quotient;
  logic          tq_ok;

  rtnh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign tq_ok = !ovf && (quotient > QB'(epsilon)) && (quotient < best_dist);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!empty) begin
        state_next = head.cand ? B_DIV_T : B_OUT;
      end
      B_DIV_T: if (div_done) begin
        state_next = tq_ok ? B_DIV_U : B_OUT;
      end
      B_DIV_U: if (div_done) begin
        state_next = B_DIV_V;
      end
      B_DIV_V: if (div_done) begin
        state_next = B_OUT;
      end
      B_OUT: if (!out_stall) begin
        state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop          = (state == B_IDLE) && !empty;
    div_start    = 1'b0;
    div_dividend = RW'(cur.nu) << FRAC_BITS;
    div_divisor  = cur.det;
    unique case (state)
      B_IDLE: begin
        div_start    = !empty && head.cand;
        div_dividend = RW'(head.nt) << FRAC_BITS;
        div_divisor  = head.det;
      end
      B_DIV_T: begin
        div_start = div_done && tq_ok;
      end
      B_DIV_U: begin
        div_start    = div_done;
        div_dividend = RW'(cur.nv) << FRAC_BITS;
      end
      default: begin
      end
    endcase
    out_valid                 = (state == B_OUT);
    out_data.updated          = upd;
    out_data.any_hit          = hit_held;
    out_data.nearest_distance = best_dist;
    out_data.nearest_u        = best_u;
    out_data.nearest_v        = best_v;
    out_data.nearest_triangle = best_tri;
    out_data.nearest_instance = best_inst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_dist <= '1;
      best_u    <= '0;
      best_v    <= '0;
      best_tri  <= '0;
      best_inst <= '0;
      hit_held  <= 1'b0;
      upd       <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: if (!empty) begin
          cur <= head;
          ovf <= ((RW'(head.nt) << FRAC_BITS) >= (RW'(head.det) << QB));
          upd <= 1'b0;
          if (head.restart) begin
            best_dist <= distance_limit;
            best_u    <= '0;
            best_v    <= '0;
            best_tri  <= '0;
            best_inst <= '0;
            hit_held  <= 1'b0;
          end
        end
        B_DIV_T: if (div_done) begin
          tq <= quotient;
        end
        B_DIV_U: if (div_done) begin
          u_tmp <= quotient[16:0];
        end
        B_DIV_V: if (div_done) begin
          best_dist <= tq;
          best_u    <= u_tmp;
          best_v    <= quotient[16:0];
          best_tri  <= cur.triangle_id;
          best_inst <= cur.instance_id;
          hit_held  <= 1'b1;
          upd       <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> sv/ray_triangle_nearest_hit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit
// Nearest-hit search of one configured ray against a stream of triangles.
// ----------------------------------------------------------------------------
// Each triangle beat yields one result beat holding the nearest hit so far.
// A triangle runs through the front as 24 exact products on one shared
// 33x23-bit multiplier, three chunks and one accumulate each. A candidate
// then passes through the back's one-bit-per-cycle divider for distance
// and, on a closer hit, u and v; a rejected triangle goes straight to the
// result. A two-beat queue between front and back lets the front take the
// next triangle while a result waits.
// ----------------------------------------------------------------------------
module ray_triangle_nearest_hit #(
  parameter int FRAC_BITS        = 16,
  parameter int INSTANCE_ID_BITS = 16,
  parameter int TRIANGLE_ID_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rtnh_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output rtnh_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);
  import rtnh_pkg::*;

  ray_cfg_t    ray;
  logic [30:0] distance_limit;
  logic [15:0] epsilon;
  logic        push, full, pop, empty;
  qitem_t      q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ray.origin_x   <= '0;
      ray.origin_y   <= '0;
      ray.origin_z   <= '0;
      ray.dir_x      <= '0;
      ray.dir_y      <= '0;
      ray.dir_z      <= 32'sd65536;
      distance_limit <= '1;
      epsilon        <= 16'd66;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: ray.origin_x   <= cfg_data;
        CFG_ORIGIN_Y: ray.origin_y   <= cfg_data;
        CFG_ORIGIN_Z: ray.origin_z   <= cfg_data;
        CFG_DIR_X:    ray.dir_x      <= cfg_data;
        CFG_DIR_Y:    ray.dir_y      <= cfg_data;
        CFG_DIR_Z:    ray.dir_z      <= cfg_data;
        CFG_LIMIT:    distance_limit <= cfg_data[30:0];
        CFG_EPSILON:  epsilon        <= cfg_data[15:0];
        default:      epsilon        <= epsilon;
      endcase
    end
  end

  rtnh_front #(
    .FRAC_BITS        (FRAC_BITS),
    .INSTANCE_ID_BITS (INSTANCE_ID_BITS),
    .TRIANGLE_ID_BITS (TRIANGLE_ID_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .ray      (ray),
    .epsilon  (epsilon),
    .push     (push),
    .full     (full),
    .item     (q_wdata)
  );

  rtnh_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .full  (full),
    .pop   (pop),
    .empty (empty),
    .rdata (q_rdata)
  );

  rtnh_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .empty          (empty),
    .pop            (pop),
    .head           (q_rdata),
    .distance_limit (distance_limit),
    .epsilon        (epsilon),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule

>>> sv/rtnh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnh_checker
// Port-level checks on the nearest-hit results, bound to the top level.
// ----------------------------------------------------------------------------
module rtnh_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_stall,
  input rtnh_pkg::out_t out_data
);
  import rtnh_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_upd_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.updated |-> out_data.any_hit)
    else $error("update without a held hit");

  a_no_hit_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.any_hit |-> out_data.nearest_u == '0
      && out_data.nearest_v == '0 && out_data.nearest_triangle == '0
      && out_data.nearest_instance == '0)
    else $error("hit fields set with no hit held");

  a_upd_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.updated |-> out_data.nearest_distance != '0)
    else $error("hit at zero distance");

endmodule

bind ray_triangle_nearest_hit rtnh_checker u_rtnh_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/ray_triangle_nearest_hit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit_tb
// Self-checking bench for the ray/triangle nearest-hit block.
// ----------------------------------------------------------------------------
// Streams triangles against several configured rays: directed corner cases,
// register extremes, then random triangles, most aimed so they straddle the
// ray. An exact wide-integer model tracks the nearest hit and every result
// beat is compared field by field. Both sides throttle at random.
// ----------------------------------------------------------------------------
module ray_triangle_nearest_hit_tb;
  import rtnh_pkg::*;

  typedef logic signed [191:0] wide_t;

  localparam int ONE = 65536;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  // register shadow
  logic signed [31:0] org_x, org_y, org_z, dir_x, dir_y, dir_z;
  logic [30:0] dist_limit;
  logic [15:0] eps;

  // nearest-hit state
  logic [30:0] best_dist;
  logic [16:0] best_u, best_v;
  logic [15:0] best_tri, best_inst;
  logic hit_held;

  out_t nearest_q[$];
  int mismatch_count;
  int idle_cycles;
  int burst_left;
  int stall_left;
  int stall_mode;

  ray_triangle_nearest_hit i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic out_t trace_triangle(in_t t);
    wide_t dx, dy, dz, e1x, e1y, e1z, e2x, e2y, e2z, tx, ty, tz;
    wide_t px, py, pz, qx, qy, qz, det, nu, nv, nt, tq, epsw, uq, vq;
    out_t r;
    if (t.restart) begin
      best_dist = dist_limit;
      best_u = '0;
      best_v = '0;
      best_tri = '0;
      best_inst = '0;
      hit_held = 1'b0;
    end
    dx = wide_t'(dir_x);
    dy = wide_t'(dir_y);
    dz = wide_t'(dir_z);
    e1x = wide_t'(t.v1_x) - wide_t'(t.v0_x);
    e1y = wide_t'(t.v1_y) - wide_t'(t.v0_y);
    e1z = wide_t'(t.v1_z) - wide_t'(t.v0_z);
    e2x = wide_t'(t.v2_x) - wide_t'(t.v0_x);
    e2y = wide_t'(t.v2_y) - wide_t'(t.v0_y);
    e2z = wide_t'(t.v2_z) - wide_t'(t.v0_z);
    tx = wide_t'(org_x) - wide_t'(t.v0_x);
    ty = wide_t'(org_y) - wide_t'(t.v0_y);
    tz = wide_t'(org_z) - wide_t'(t.v0_z);
    px = dy * e2z - dz * e2y;
    py = dz * e2x - dx * e2z;
    pz = dx * e2y - dy * e2x;
    det = e1x * px + e1y * py + e1z * pz;
    nu = tx * px + ty * py + tz * pz;
    qx = ty * e1z - tz * e1y;
    qy = tz * e1x - tx * e1z;
    qz = tx * e1y - ty * e1x;
    nv = dx * qx + dy * qy + dz * qz;
    nt = e2x * qx + e2y * qy + e2z * qz;
    if (det < 0) begin
      det = -det;
      nu = -nu;
      nv = -nv;
      nt = -nt;
    end
    epsw = wide_t'({1'b0, eps});
    r.updated = 1'b0;
    if (det != 0 && det >= (epsw <<< 32) && nu >= 0 && nu <= det && nv >= 0
        && nu + nv <= det && nt > 0) begin
      tq = (nt <<< 16) / det;
      if (tq > epsw && tq < wide_t'({1'b0, best_dist})) begin
        uq = (nu <<< 16) / det;
        vq = (nv <<< 16) / det;
        best_dist = tq[30:0];
        best_u = uq[16:0];
        best_v = vq[16:0];
        best_tri = t.triangle_id;
        best_inst = t.instance_id;
        hit_held = 1'b1;
        r.updated = 1'b1;
      end
    end
    r.any_hit = hit_held;
    r.nearest_distance = best_dist;
    r.nearest_u = best_u;
    r.nearest_v = best_v;
    r.nearest_triangle = best_tri;
    r.nearest_instance = best_inst;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < 30) begin
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (nearest_q.size() == 0) begin
        report_mismatch("unexpected beat", 32'(out_data.nearest_distance), '0);
      end else begin
        want = nearest_q.pop_front();
        if (out_data.updated !== want.updated)
          report_mismatch("updated", 32'(out_data.updated), 32'(want.updated));
        if (out_data.any_hit !== want.any_hit)
          report_mismatch("any_hit", 32'(out_data.any_hit), 32'(want.any_hit));
        if (out_data.nearest_distance !== want.nearest_distance)
          report_mismatch("distance", 32'(out_data.nearest_distance),
                          32'(want.nearest_distance));
        if (out_data.nearest_u !== want.nearest_u)
          report_mismatch("u", 32'(out_data.nearest_u), 32'(want.nearest_u));
        if (out_data.nearest_v !== want.nearest_v)
          report_mismatch("v", 32'(out_data.nearest_v), 32'(want.nearest_v));
        if (out_data.nearest_triangle !== want.nearest_triangle)
          report_mismatch("triangle", 32'(out_data.nearest_triangle),
                          32'(want.nearest_triangle));
        if (out_data.nearest_instance !== want.nearest_instance)
          report_mismatch("instance", 32'(out_data.nearest_instance),
                          32'(want.nearest_instance));
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      stall_mode <= 0;
    end else if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 300);
      out_stall <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_triangle(in_t t);
    int gap;
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    nearest_q.push_back(trace_triangle(t));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ORIGIN_X: org_x = value;
      CFG_ORIGIN_Y: org_y = value;
      CFG_ORIGIN_Z: org_z = value;
      CFG_DIR_X: dir_x = value;
      CFG_DIR_Y: dir_y = value;
      CFG_DIR_Z: dir_z = value;
      CFG_LIMIT: dist_limit = value[30:0];
      default: eps = value[15:0];
    endcase
  endtask

  task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_DIR_Z, dz);
  endtask

  function automatic in_t make_tri(logic rs, int ax, int ay, int az, int bx, int by,
                                   int bz, int cx, int cy, int cz);
    in_t t;
    t.restart = rs;
    t.v0_x = ax;
    t.v0_y = ay;
    t.v0_z = az;
    t.v1_x = bx;
    t.v1_y = by;
    t.v1_z = bz;
    t.v2_x = cx;
    t.v2_y = cy;
    t.v2_z = cz;
    t.instance_id = 16'($urandom());
    t.triangle_id = 16'($urandom());
    return t;
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic in_t any_tri();
    in_t t;
    t = make_tri($urandom_range(0, 9) == 0, $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    return t;
  endfunction

  // triangle around a point on the ray, so most of them are hit
  function automatic in_t aimed_tri();
    longint hit_t, cx, cy, cz;
    int span;
    hit_t = longint'($urandom_range(0, 64 * ONE))
            - (($urandom_range(0, 7) == 0) ? longint'(8 * ONE) : longint'(0));
    cx = longint'(org_x) + ((longint'(dir_x) * hit_t) >>> 16);
    cy = longint'(org_y) + ((longint'(dir_y) * hit_t) >>> 16);
    cz = longint'(org_z) + ((longint'(dir_z) * hit_t) >>> 16);
    span = ($urandom_range(0, 3) == 0) ? 256 * ONE : 8 * ONE;
    return make_tri($urandom_range(0, 9) == 0,
                    int'(cx) + spread(span), int'(cy) + spread(span), int'(cz) + spread(span),
                    int'(cx) + spread(span), int'(cy) + spread(span), int'(cz) + spread(span),
                    int'(cx) + spread(span), int'(cy) + spread(span), int'(cz) + spread(span));
  endfunction

  task automatic test_directed();
    send_triangle(make_tri(1, -ONE, -ONE, 5 * ONE, 3 * ONE, -ONE, 5 * ONE,
                           -ONE, 3 * ONE, 5 * ONE));
    send_triangle(make_tri(0, -ONE, -ONE, 8 * ONE, 3 * ONE, -ONE, 8 * ONE,
                           -ONE, 3 * ONE, 8 * ONE));
    send_triangle(make_tri(0, -ONE, -ONE, 2 * ONE, -ONE, 3 * ONE, 2 * ONE,
                           3 * ONE, -ONE, 2 * ONE));
    send_triangle(make_tri(0, -ONE, -ONE, -3 * ONE, 3 * ONE, -ONE, -3 * ONE,
                           -ONE, 3 * ONE, -3 * ONE));
    send_triangle(make_tri(0, 9 * ONE, -ONE, ONE, 13 * ONE, -ONE, ONE,
                           9 * ONE, 3 * ONE, ONE));
    send_triangle(make_tri(0, 0, 0, ONE, ONE, ONE, ONE, 2 * ONE, 2 * ONE, ONE));
    send_triangle(make_tri(1, 0, 0, ONE / 2, 2 * ONE, 0, ONE / 2, 0, 2 * ONE, ONE / 2));
    send_triangle(make_tri(0, -ONE, -ONE, ONE / 4, ONE, -ONE, ONE / 4, -ONE, ONE, ONE / 4));
    send_triangle(make_tri(1, -ONE, -ONE, 32, 3 * ONE, -ONE, 32, -ONE, 3 * ONE, 32));
    send_triangle(make_tri(0, -ONE, -ONE, 66, 3 * ONE, -ONE, 66, -ONE, 3 * ONE, 66));
    send_triangle(make_tri(0, -ONE, -ONE, 67, 3 * ONE, -ONE, 67, -ONE, 3 * ONE, 67));
    send_triangle(make_tri(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           32'h7fffffff));
    send_triangle(make_tri(1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                           32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                           32'h7fffffff));
    send_triangle(make_tri(0, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                           32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                           32'h55555555));
    send_triangle(make_tri(0, 32'h80000000, 32'h80000000, 3 * ONE, 32'h7fffffff,
                           32'h80000000, 3 * ONE, 32'h80000000, 32'h7fffffff, 3 * ONE));
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_EPSILON, 0);
    send_triangle(make_tri(1, 0, 0, ONE, ONE, ONE, ONE, 2 * ONE, 2 * ONE, ONE));
    send_triangle(make_tri(0, -ONE, -ONE, 1, 3 * ONE, -ONE, 1, -ONE, 3 * ONE, 1));
    drain();
    set_ray(0, 0, 0, 0, 0, 0);
    send_triangle(make_tri(1, -ONE, -ONE, 5 * ONE, 3 * ONE, -ONE, 5 * ONE,
                           -ONE, 3 * ONE, 5 * ONE));
    drain();
    set_ray(ONE / 3, -ONE / 5, 0, 0, 0, ONE);
    write_reg(CFG_LIMIT, 0);
    send_triangle(make_tri(1, -ONE, -ONE, 5 * ONE, 3 * ONE, -ONE, 5 * ONE,
                           -ONE, 3 * ONE, 5 * ONE));
    drain();
    write_reg(CFG_LIMIT, 4 * ONE);
    write_reg(CFG_EPSILON, 16'hffff);
    send_triangle(make_tri(1, -ONE, -ONE, 5 * ONE, 3 * ONE, -ONE, 5 * ONE,
                           -ONE, 3 * ONE, 5 * ONE));
    send_triangle(make_tri(0, -ONE, -ONE, 3 * ONE, 3 * ONE, -ONE, 3 * ONE,
                           -ONE, 3 * ONE, 3 * ONE));
    send_triangle(make_tri(0, -ONE, -ONE, 2 * ONE, 3 * ONE, -ONE, 2 * ONE,
                           -ONE, 3 * ONE, 2 * ONE));
    drain();
    write_reg(CFG_LIMIT, 32'h7fffffff);
    write_reg(CFG_EPSILON, 66);
    set_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
            32'h80000000);
    repeat (4) send_triangle(any_tri());
    drain();
  endtask

  task automatic run_random(int count, int aimed_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < aimed_pct) send_triangle(aimed_tri());
      else send_triangle(any_tri());
      if ($urandom_range(0, 149) == 0) drain();
    end
    drain();
  endtask

  task automatic test_random_rays();
    set_ray(0, 0, 0, 0, 0, ONE);
    run_random(250, 80);
    set_ray(spread(1000 * ONE), spread(1000 * ONE), spread(1000 * ONE),
            spread(4 * ONE), spread(4 * ONE), spread(4 * ONE));
    write_reg(CFG_EPSILON, $urandom_range(0, 65535));
    write_reg(CFG_LIMIT, $urandom_range(ONE, 80 * ONE));
    run_random(250, 75);
    set_ray(spread(1000 * ONE), spread(1000 * ONE), spread(1000 * ONE),
            spread(ONE / 8), spread(ONE / 8), spread(4 * ONE));
    write_reg(CFG_EPSILON, $urandom_range(0, 200));
    write_reg(CFG_LIMIT, 32'h7fffffff);
    run_random(300, 80);
    set_ray(spread(1000 * ONE), spread(1000 * ONE), spread(1000 * ONE),
            spread(4 * ONE), spread(4 * ONE), spread(4 * ONE));
    write_reg(CFG_EPSILON, 66);
    run_random(300, 75);
    set_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    write_reg(CFG_LIMIT, $urandom());
    run_random(200, 20);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    org_x = 0;
    org_y = 0;
    org_z = 0;
    dir_x = 0;
    dir_y = 0;
    dir_z = ONE;
    dist_limit = 31'h7fffffff;
    eps = 66;
    best_dist = 31'h7fffffff;
    best_u = '0;
    best_v = '0;
    best_tri = '0;
    best_inst = '0;
    hit_held = 1'b0;
    mismatch_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_rays();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && nearest_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> ray_triangle_nearest_hit.f
sv/rtnh_pkg.sv
sv/rtnh_fifo.sv
sv/rtnh_front.sv
sv/rtnh_div.sv
sv/rtnh_back.sv
sv/ray_triangle_nearest_hit.sv
sv/rtnh_checker.sv
tb/ray_triangle_nearest_hit_tb.sv
